// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the transcoder.
// Both macros assume a clock named clk in scope; ASSERT_RUN also a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check only while out of reset.
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- hw/rtl/utc_pkg.sv -----
// Shared types, constants and the code-to-byte lookup of the transcoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utc_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int ROM_PAIRS = 63;

  localparam logic [15:0] CYR_LO     = 16'd1040;
  localparam logic [15:0] CYR_HI     = 16'd1103;
  localparam logic [15:0] CYR_OFFSET = 16'd848;

  // What the front hands to the back for each character.
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_CODE,
    KIND_ERR
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic        two_byte;
    logic [15:0] code;
  } mid_item_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] cp_byte;
  } rom_hit_t;

  localparam logic [15:0] ROM_CODE [ROM_PAIRS] = '{
    16'd160, 16'd164, 16'd166, 16'd167, 16'd169, 16'd171, 16'd172, 16'd173,
    16'd174, 16'd176, 16'd177, 16'd181, 16'd182, 16'd183, 16'd187,
    16'd1025, 16'd1026, 16'd1027, 16'd1028, 16'd1029, 16'd1030, 16'd1031,
    16'd1032, 16'd1033, 16'd1034, 16'd1035, 16'd1036, 16'd1038, 16'd1039,
    16'd1105, 16'd1106, 16'd1107, 16'd1108, 16'd1109, 16'd1110, 16'd1111,
    16'd1112, 16'd1113, 16'd1114, 16'd1115, 16'd1116, 16'd1118, 16'd1119,
    16'd1168, 16'd1169, 16'd8211, 16'd8212, 16'd8216, 16'd8217, 16'd8218,
    16'd8220, 16'd8221, 16'd8222, 16'd8224, 16'd8225, 16'd8226, 16'd8230,
    16'd8240, 16'd8249, 16'd8250, 16'd8364, 16'd8470, 16'd8482
  };

  localparam logic [7:0] ROM_BYTE [ROM_PAIRS] = '{
    8'd160, 8'd164, 8'd166, 8'd167, 8'd169, 8'd171, 8'd172, 8'd173,
    8'd174, 8'd176, 8'd177, 8'd181, 8'd182, 8'd183, 8'd187,
    8'd168, 8'd128, 8'd129, 8'd170, 8'd189, 8'd178, 8'd175,
    8'd163, 8'd138, 8'd140, 8'd142, 8'd141, 8'd161, 8'd143,
    8'd184, 8'd144, 8'd131, 8'd186, 8'd190, 8'd179, 8'd191,
    8'd188, 8'd154, 8'd156, 8'd158, 8'd157, 8'd162, 8'd159,
    8'd165, 8'd180, 8'd150, 8'd151, 8'd145, 8'd146, 8'd130,
    8'd147, 8'd148, 8'd132, 8'd134, 8'd135, 8'd149, 8'd133,
    8'd137, 8'd139, 8'd155, 8'd136, 8'd185, 8'd153
  };

  // Parallel match of a code point against every ROM pair.
  function automatic rom_hit_t rom_lookup(input logic [15:0] code);
    rom_hit_t res;
    res = '0;
    for (int i = 0; i < ROM_PAIRS; i++) begin
      if (ROM_CODE[i] == code) begin
        res.hit     = 1'b1;
        res.cp_byte = ROM_BYTE[i];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/utc_queue.sv -----
// Small register queue between front and back of the transcoder.
// Depends on utc_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module utc_queue #(
  parameter int DEPTH = utc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire utc_pkg::mid_item_t wdata,
  output logic                   full,
  input  wire logic              pop,
  output utc_pkg::mid_item_t     rdata,
  output logic                   empty
);
  import utc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mid_item_t       entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/utc_front.sv -----
// Front of the transcoder: takes UTF-8 bytes, gathers code point bits and
// classifies each finished character. Depends on utc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        in_byte,
  output logic                   mid_push,
  output utc_pkg::mid_item_t     mid_item
);
  import utc_pkg::*;

  logic [1:0]  pending;
  logic [1:0]  pending_next;
  logic        two_byte;
  logic        two_byte_next;
  logic [15:0] partial;
  logic [15:0] partial_next;

  always_comb begin
    pending_next  = pending;
    two_byte_next = two_byte;
    partial_next  = partial;
    mid_push      = 1'b0;
    mid_item      = '{kind: KIND_PASS, two_byte: 1'b0, code: 16'h0000};
    if (take) begin
      case (pending)
        2'd2: begin
          partial_next = partial | {4'h0, in_byte[5:0], 6'h00};
          pending_next = 2'd1;
        end
        2'd1: begin
          mid_push      = 1'b1;
          mid_item      = '{kind: KIND_CODE, two_byte: two_byte,
                            code: partial | {10'h000, in_byte[5:0]}};
          pending_next  = 2'd0;
          two_byte_next = 1'b0;
          partial_next  = '0;
        end
        default: begin
          // idle; a count of three cannot occur and is treated the same
          pending_next  = 2'd0;
          two_byte_next = 1'b0;
          partial_next  = '0;
          if (!in_byte[7]) begin
            mid_push = 1'b1;
            mid_item = '{kind: KIND_PASS, two_byte: 1'b0, code: {8'h00, in_byte}};
          end else if (in_byte[7:5] != 3'b111) begin
            partial_next  = {5'h00, in_byte[4:0], 6'h00};
            two_byte_next = 1'b1;
            pending_next  = 2'd1;
          end else if (!in_byte[4]) begin
            partial_next = {in_byte[3:0], 12'h000};
            pending_next = 2'd2;
          end else begin
            mid_push = 1'b1;
            mid_item = '{kind: KIND_ERR, two_byte: 1'b0, code: 16'h0000};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 2'd0;
      two_byte <= 1'b0;
      partial  <= '0;
    end else begin
      pending  <= pending_next;
      two_byte <= two_byte_next;
      partial  <= partial_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/utc_back.sv -----
// Back of the transcoder: maps classified characters to Windows-1251 bytes
// and holds the result in an output register. Depends on utc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire utc_pkg::mid_item_t mid_item,
  input  wire logic              mid_empty,
  output logic                   mid_pop,
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             out_byte,
  output logic                   bad_char
);
  import utc_pkg::*;

  logic       out_valid;
  logic [7:0] byte_next;
  logic       bad_next;
  rom_hit_t   rom_res;
  logic       in_cyr;

  assign empty   = !out_valid;
  // Load when the slot is free or its result leaves this cycle.
  assign mid_pop = !mid_empty && (!out_valid || pop);

  assign rom_res = rom_lookup(mid_item.code);
  assign in_cyr  = mid_item.two_byte && (mid_item.code >= CYR_LO) &&
                   (mid_item.code <= CYR_HI);

  always_comb begin
    byte_next = 8'h00;
    bad_next  = 1'b1;
    case (mid_item.kind)
      KIND_PASS: begin
        byte_next = mid_item.code[7:0];
        bad_next  = 1'b0;
      end
      KIND_CODE: begin
        if (in_cyr) begin
          byte_next = 8'(mid_item.code - CYR_OFFSET);
          bad_next  = 1'b0;
        end else if (rom_res.hit) begin
          byte_next = rom_res.cp_byte;
          bad_next  = 1'b0;
        end
      end
      default: begin
        byte_next = 8'h00;
        bad_next  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      out_byte <= byte_next;
      bad_char <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_to_cp1251_transcoder.sv -----
// UTF-8 to Windows-1251 transcoder, top level; uses utc_pkg, utc_front,
// utc_queue, utc_back and assert_macros.svh.
// Throughput: one input byte per cycle, held only by a full queue.
// A finished character is queued, then loaded into the output register when that is free.
// Reset clears the sequence state, the queue and the output valid flag, not out_byte.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8_to_cp1251_transcoder #(
  parameter int QUEUE_DEPTH = utc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            bad_char
);
  import utc_pkg::*;

  logic      take;
  logic      mid_push;
  mid_item_t mid_wdata;
  logic      mid_full;
  logic      mid_pop;
  mid_item_t mid_rdata;
  logic      mid_empty;

  assign full = mid_full;
  assign take = push && !mid_full;

  utc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_byte  (in_byte),
    .mid_push (mid_push),
    .mid_item (mid_wdata)
  );

  utc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  utc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_item  (mid_rdata),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .bad_char  (bad_char)
  );

  `ASSERT_ALWAYS(a_empty_after_rst, rst |=> empty, "result pending after reset")
  `ASSERT_RUN(a_err_zero_byte, (!empty && bad_char) |-> out_byte == 8'h00, "nonzero error byte")
  `ASSERT_RUN(a_no_push_full, mid_push |-> !mid_full, "front pushed into full queue")
  `ASSERT_RUN(a_load_on_free, mid_pop |=> !empty, "loaded result not shown")

endmodule

`default_nettype wire

// ----- dv/utc_checker.sv -----
// Checker for the UTF-8 to Windows-1251 transcoder: watches both request
// channels, predicts each character and compares the popped results.
// Standalone; uses no package items.
`timescale 1ns / 1ps

module utc_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       bad_char,
  output int         fail_count,
  output int         waiting
);

  typedef struct packed {
    logic [7:0] cp;
    logic       bad;
  } cp_char_t;

  cp_char_t    expected_chars[$];
  logic [1:0]  seq_left;
  logic        seq_two;
  logic [15:0] code_acc;

  initial begin
    fail_count = 0;
    waiting    = 0;
  end

  function automatic void cp1251_lookup(input logic [15:0] code, output logic hit,
                                        output logic [7:0] cp);
    hit = 1'b1;
    cp  = 8'd0;
    case (code)
      16'd160, 16'd164, 16'd166, 16'd167, 16'd169, 16'd171, 16'd172, 16'd173,
      16'd174, 16'd176, 16'd177, 16'd181, 16'd182, 16'd183, 16'd187: cp = code[7:0];
      16'd1025: cp = 8'd168;  16'd1026: cp = 8'd128;  16'd1027: cp = 8'd129;
      16'd1028: cp = 8'd170;  16'd1029: cp = 8'd189;  16'd1030: cp = 8'd178;
      16'd1031: cp = 8'd175;  16'd1032: cp = 8'd163;  16'd1033: cp = 8'd138;
      16'd1034: cp = 8'd140;  16'd1035: cp = 8'd142;  16'd1036: cp = 8'd141;
      16'd1038: cp = 8'd161;  16'd1039: cp = 8'd143;
      16'd1105: cp = 8'd184;  16'd1106: cp = 8'd144;  16'd1107: cp = 8'd131;
      16'd1108: cp = 8'd186;  16'd1109: cp = 8'd190;  16'd1110: cp = 8'd179;
      16'd1111: cp = 8'd191;  16'd1112: cp = 8'd188;  16'd1113: cp = 8'd154;
      16'd1114: cp = 8'd156;  16'd1115: cp = 8'd158;  16'd1116: cp = 8'd157;
      16'd1118: cp = 8'd162;  16'd1119: cp = 8'd159;
      16'd1168: cp = 8'd165;  16'd1169: cp = 8'd180;
      16'd8211: cp = 8'd150;  16'd8212: cp = 8'd151;  16'd8216: cp = 8'd145;
      16'd8217: cp = 8'd146;  16'd8218: cp = 8'd130;  16'd8220: cp = 8'd147;
      16'd8221: cp = 8'd148;  16'd8222: cp = 8'd132;  16'd8224: cp = 8'd134;
      16'd8225: cp = 8'd135;  16'd8226: cp = 8'd149;  16'd8230: cp = 8'd133;
      16'd8240: cp = 8'd137;  16'd8249: cp = 8'd139;  16'd8250: cp = 8'd155;
      16'd8364: cp = 8'd136;  16'd8470: cp = 8'd185;  16'd8482: cp = 8'd153;
      default: hit = 1'b0;
    endcase
  endfunction

  // Advance the sequence state by one byte; report a character if one completes.
  function automatic void transcode_byte(input logic [7:0] b, output logic done,
                                         output cp_char_t ch);
    logic [15:0] code;
    logic        hit;
    logic [7:0]  cp;
    done = 1'b0;
    ch   = '0;
    if (seq_left == 2'd2) begin
      code_acc = code_acc | {4'd0, b[5:0], 6'd0};
      seq_left = 2'd1;
    end else if (seq_left == 2'd1) begin
      code     = code_acc | {10'd0, b[5:0]};
      done     = 1'b1;
      seq_left = 2'd0;
      code_acc = '0;
      if (seq_two && code >= 16'd1040 && code <= 16'd1103) begin
        ch.cp = 8'(code - 16'd848);
      end else begin
        cp1251_lookup(code, hit, cp);
        ch.cp  = hit ? cp : 8'd0;
        ch.bad = !hit;
      end
      seq_two = 1'b0;
    end else begin
      seq_left = 2'd0;
      seq_two  = 1'b0;
      code_acc = '0;
      if (b < 8'd128) begin
        done  = 1'b1;
        ch.cp = b;
      end else if (b < 8'd224) begin
        code_acc = {5'd0, b[4:0], 6'd0};
        seq_two  = 1'b1;
        seq_left = 2'd1;
      end else if (b < 8'd240) begin
        code_acc = {b[3:0], 12'd0};
        seq_left = 2'd2;
      end else begin
        done   = 1'b1;
        ch.bad = 1'b1;
      end
    end
  endfunction

  cp_char_t want;
  cp_char_t next_char;
  logic     char_done;

  always @(posedge clk) begin
    if (rst) begin
      seq_left = '0;
      seq_two  = 1'b0;
      code_acc = '0;
      expected_chars.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result: out_byte %0d bad_char %0b", out_byte, bad_char);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want.cp) begin
            $error("out_byte: expected %0d, got %0d", want.cp, out_byte);
            fail_count++;
          end
          if (bad_char !== want.bad) begin
            $error("bad_char: expected %0b, got %0b", want.bad, bad_char);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        transcode_byte(in_byte, char_done, next_char);
        if (char_done) expected_chars.push_back(next_char);
      end
    end
    waiting = expected_chars.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Top of the transcoder testbench: clock, reset, byte stream and result pops.
// Depends on utf8_to_cp1251_transcoder, utc_pkg and utc_checker.
`timescale 1ns / 1ps

module tb_top;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       bad_char;
  int         fail_count;
  int         waiting;
  int         rx_hold_cycles = 0;
  int         bytes_sent = 0;
  int         tx_calm = 0;
  int         rx_calm = 0;

  utf8_to_cp1251_transcoder u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .empty(empty), .pop(pop), .out_byte(out_byte), .bad_char(bad_char)
  );

  utc_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .empty(empty), .pop(pop), .out_byte(out_byte), .bad_char(bad_char),
    .fail_count(fail_count), .waiting(waiting)
  );

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // Mostly random idle cycles, with occasional stretches of back-to-back requests.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 18);
  endfunction

  // Entered and left at a falling edge; push stays high when the next byte follows.
  task automatic send_byte(input logic [7:0] b, input bit hurry);
    int gap;
    gap = hurry ? 0 : draw_gap(tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Encode a code point; noisy continuation bytes get random top bits.
  task automatic send_code(input logic [15:0] code, input bit three, input bit noisy);
    logic [1:0] t1;
    logic [1:0] t2;
    t1 = noisy ? 2'($urandom_range(0, 3)) : 2'b10;
    t2 = noisy ? 2'($urandom_range(0, 3)) : 2'b10;
    if (three) begin
      send_byte({4'b1110, code[15:12]}, 1'b0);
      send_byte({t1, code[11:6]}, 1'b0);
    end else begin
      send_byte({3'b110, code[10:6]}, 1'b0);
    end
    send_byte({t2, code[5:0]}, 1'b0);
  endtask

  initial begin
    int wait_n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        wait_n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        wait_n = draw_gap(rx_calm);
      end
      if (wait_n > 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [7:0] directed[$];
    logic [15:0] code;
    bit          did_hold;
    bit          did_drain;
    int          kind;
    did_hold  = 1'b0;
    did_drain = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ASCII ends, Cyrillic range ends, ROM hits in both lengths, the 3-byte
    // Cyrillic miss, high leads, a 2-byte miss, a stray continuation as lead,
    // ignored continuation top bits and the largest 3-byte code.
    directed = '{8'h00, 8'h7F, 8'hD0, 8'h90, 8'hD1, 8'h8F, 8'hD0, 8'h81,
                 8'hE2, 8'h84, 8'hA2, 8'hE0, 8'h90, 8'h90, 8'hF0, 8'hFF,
                 8'hC2, 8'h80, 8'h80, 8'h80, 8'hD0, 8'h10, 8'hEF, 8'hFF, 8'hFF};
    foreach (directed[i]) send_byte(directed[i], 1'b0);

    while (bytes_sent < 575) begin
      if (!did_hold && bytes_sent >= 180) begin
        // Stall the receiver while bytes keep coming, so the queue fills up.
        did_hold = 1'b1;
        rx_hold_cycles = 80;
        repeat (30) send_byte(8'($urandom_range(0, 127)), 1'b1);
      end
      if (!did_drain && bytes_sent >= 380) begin
        did_drain = 1'b1;
        push <= 1'b0;
        do @(negedge clk); while (waiting != 0);
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: send_byte(8'($urandom_range(0, 127)), 1'b0);
        2, 3: send_code(16'($urandom_range(1040, 1103)), $urandom_range(0, 7) == 0,
                        $urandom_range(0, 3) == 0);
        4, 5: begin
          code = utc_pkg::ROM_CODE[$urandom_range(0, utc_pkg::ROM_PAIRS - 1)];
          send_code(code, code > 16'd2047 || $urandom_range(0, 5) == 0,
                    $urandom_range(0, 3) == 0);
        end
        6: send_code(16'($urandom_range(0, 2047)), 1'b0, $urandom_range(0, 1) == 0);
        7: send_code(16'($urandom_range(0, 65535)), 1'b1, $urandom_range(0, 1) == 0);
        8: send_byte(8'($urandom_range(240, 255)), 1'b0);
        default: send_byte(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end

    push <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/utc_pkg.sv
hw/rtl/utc_queue.sv
hw/rtl/utc_front.sv
hw/rtl/utc_back.sv
hw/rtl/utf8_to_cp1251_transcoder.sv
dv/utc_checker.sv
dv/tb_top.sv
